FILE: rtl/core/kpbc_pkg.sv
// Shared types, codes and the fixed key table for the keyed packet body cipher.
package kpbc_pkg;

    typedef logic [7:0] byte_t;

    localparam int KEY_ROM_DEPTH = 512;
    localparam int KEY_AW        = 8;      // address width of each half (even / odd)

    localparam logic [2:0] HDR_LEN  = 3'd4; // header bytes, also the position cap
    localparam logic [2:0] POS_KEY  = 3'd2; // decrypt: key index byte
    localparam logic [2:0] POS_CSUM = 3'd3; // decrypt: expected checksum byte

    typedef enum logic {
        MODE_DEC = 1'b0,
        MODE_ENC = 1'b1
    } mode_t;

    // byte position mod 4 picks the key operation
    typedef enum logic [1:0] {
        PH_SHL1 = 2'd0,
        PH_SHR3 = 2'd1,
        PH_SHL2 = 2'd2,
        PH_SHR5 = 2'd3
    } phase_t;

    // one word handed from the front stage to the back stage
    typedef struct packed {
        logic   first;
        logic   body;
        logic   set_exp;
        logic   last;
        mode_t  mode;
        phase_t phase;
        byte_t  data;
    } item_t;

    localparam byte_t KEY_ROM [KEY_ROM_DEPTH] = '{
        8'h84, 8'h87, 8'h37, 8'hd7, 8'hea, 8'h79, 8'h91, 8'h7d,
        8'h4b, 8'h4b, 8'h85, 8'h7d, 8'h87, 8'h81, 8'h91, 8'h7c,
        8'h0f, 8'h73, 8'h91, 8'h91, 8'h87, 8'h7d, 8'h0d, 8'h7d,
        8'h86, 8'h8f, 8'h73, 8'h0f, 8'he1, 8'hdd, 8'h85, 8'h7d,
        8'h05, 8'h7d, 8'h85, 8'h83, 8'h87, 8'h9c, 8'h85, 8'h33,
        8'h0d, 8'he2, 8'h87, 8'h19, 8'h0f, 8'h79, 8'h85, 8'h86,
        8'h37, 8'h7d, 8'hd7, 8'hdd, 8'he9, 8'h7d, 8'hd7, 8'h7d,
        8'h85, 8'h79, 8'h05, 8'h7d, 8'h0f, 8'he1, 8'h87, 8'h7e,
        8'h23, 8'h87, 8'hf5, 8'h79, 8'h5f, 8'he3, 8'h4b, 8'h83,
        8'ha3, 8'ha2, 8'hae, 8'h0e, 8'h14, 8'h7d, 8'hde, 8'h7e,
        8'h85, 8'h7a, 8'h85, 8'haf, 8'hcd, 8'h7d, 8'h87, 8'ha5,
        8'h87, 8'h7d, 8'he1, 8'h7d, 8'h88, 8'h7d, 8'h15, 8'h91,
        8'h23, 8'h7d, 8'h87, 8'h7c, 8'h0d, 8'h7a, 8'h85, 8'h87,
        8'h17, 8'h7c, 8'h85, 8'h7d, 8'hac, 8'h80, 8'hbb, 8'h79,
        8'h84, 8'h9b, 8'h5b, 8'ha5, 8'hd7, 8'h8f, 8'h05, 8'h0f,
        8'h85, 8'h7e, 8'h85, 8'h80, 8'h85, 8'h98, 8'hf5, 8'h9d,
        8'ha3, 8'h1a, 8'h0d, 8'h19, 8'h87, 8'h7c, 8'h85, 8'h7d,
        8'h84, 8'h7d, 8'h85, 8'h7e, 8'he7, 8'h97, 8'h0d, 8'h0f,
        8'h85, 8'h7b, 8'hea, 8'h7d, 8'had, 8'h80, 8'had, 8'h7d,
        8'hb7, 8'haf, 8'h0d, 8'h7d, 8'he9, 8'h3d, 8'h85, 8'h7d,
        8'h87, 8'hb7, 8'h23, 8'h7d, 8'he7, 8'hb7, 8'ha3, 8'h0c,
        8'h87, 8'h7e, 8'h85, 8'ha5, 8'h7d, 8'h76, 8'h35, 8'hb9,
        8'h0d, 8'h6f, 8'h23, 8'h7d, 8'h87, 8'h9b, 8'h85, 8'h0c,
        8'he1, 8'ha1, 8'h0d, 8'h7f, 8'h87, 8'h7d, 8'h84, 8'h7a,
        8'h84, 8'h7b, 8'he1, 8'h86, 8'he8, 8'h6f, 8'hd1, 8'h79,
        8'h85, 8'h19, 8'h53, 8'h95, 8'hc3, 8'h47, 8'h19, 8'h7d,
        8'he7, 8'h0c, 8'h37, 8'h7c, 8'h23, 8'h7d, 8'h85, 8'h7d,
        8'h4b, 8'h79, 8'h21, 8'ha5, 8'h87, 8'h7d, 8'h19, 8'h7d,
        8'h0d, 8'h7d, 8'h15, 8'h91, 8'h23, 8'h7d, 8'h87, 8'h7c,
        8'h85, 8'h7a, 8'h85, 8'haf, 8'hcd, 8'h7d, 8'h87, 8'h7d,
        8'he9, 8'h3d, 8'h85, 8'h7d, 8'h15, 8'h79, 8'h85, 8'h7d,
        8'hc1, 8'h7b, 8'hea, 8'h7d, 8'hb7, 8'h7d, 8'h85, 8'h7d,
        8'h85, 8'h7d, 8'h0d, 8'h7d, 8'he9, 8'h73, 8'h85, 8'h79,
        8'h05, 8'h7d, 8'hd7, 8'h7d, 8'h85, 8'he1, 8'hb9, 8'he1,
        8'h0f, 8'h65, 8'h85, 8'h86, 8'h2d, 8'h7d, 8'hd7, 8'hdd,
        8'ha3, 8'h8e, 8'he6, 8'h7d, 8'hde, 8'h7e, 8'hae, 8'h0e,
        8'h0f, 8'he1, 8'h89, 8'h7e, 8'h23, 8'h7d, 8'hf5, 8'h79,
        8'h23, 8'he1, 8'h4b, 8'h83, 8'h0c, 8'h0f, 8'h85, 8'h7b,
        8'h85, 8'h7e, 8'h8f, 8'h80, 8'h85, 8'h98, 8'hf5, 8'h7a,
        8'h85, 8'h1a, 8'h0d, 8'he1, 8'h0f, 8'h7c, 8'h89, 8'h0c,
        8'h85, 8'h0b, 8'h23, 8'h69, 8'h87, 8'h7b, 8'h23, 8'h0c,
        8'h1f, 8'hb7, 8'h21, 8'h7a, 8'h88, 8'h7e, 8'h8f, 8'ha5,
        8'h7d, 8'h80, 8'hb7, 8'hb9, 8'h18, 8'hbf, 8'h4b, 8'h19,
        8'h85, 8'ha5, 8'h91, 8'h80, 8'h87, 8'h81, 8'h87, 8'h7c,
        8'h0f, 8'h73, 8'h91, 8'h91, 8'h84, 8'h87, 8'h37, 8'hd7,
        8'h86, 8'h79, 8'he1, 8'hdd, 8'h85, 8'h7a, 8'h73, 8'h9b,
        8'h05, 8'h7d, 8'h0d, 8'h83, 8'h87, 8'h9c, 8'h85, 8'h33,
        8'h87, 8'h7d, 8'h85, 8'h0f, 8'h87, 8'h7d, 8'h0d, 8'h7d,
        8'hf6, 8'h7e, 8'h87, 8'h7d, 8'h88, 8'h19, 8'h89, 8'hf5,
        8'hd1, 8'hdd, 8'h85, 8'h7d, 8'h8b, 8'hc3, 8'hea, 8'h7a,
        8'hd7, 8'hb0, 8'h0d, 8'h7d, 8'h87, 8'ha5, 8'h87, 8'h7c,
        8'h73, 8'h7e, 8'h7d, 8'h86, 8'h87, 8'h23, 8'h85, 8'h10,
        8'hd7, 8'hdf, 8'hed, 8'ha5, 8'he1, 8'h7a, 8'h85, 8'h23,
        8'hea, 8'h7e, 8'h85, 8'h98, 8'had, 8'h79, 8'h86, 8'h7d,
        8'h85, 8'h7d, 8'hd7, 8'h7d, 8'he1, 8'h7a, 8'hf5, 8'h7d,
        8'h85, 8'hb0, 8'h2b, 8'h37, 8'he1, 8'h7a, 8'h87, 8'h79,
        8'h84, 8'h7d, 8'h73, 8'h73, 8'h87, 8'h7d, 8'h23, 8'h7d,
        8'he9, 8'h7d, 8'h85, 8'h7e, 8'h02, 8'h7d, 8'hdd, 8'h2d,
        8'h87, 8'h79, 8'he7, 8'h79, 8'had, 8'h7c, 8'h23, 8'hda,
        8'h87, 8'h0d, 8'h0d, 8'h7b, 8'he7, 8'h79, 8'h9b, 8'h7d,
        8'hd7, 8'h8f, 8'h05, 8'h7d, 8'h0d, 8'h34, 8'h8f, 8'h7d,
        8'had, 8'h87, 8'he9, 8'h7c, 8'h85, 8'h80, 8'h85, 8'h79,
        8'h8a, 8'hc3, 8'he7, 8'ha5, 8'he8, 8'h6b, 8'h0d, 8'h74,
        8'h10, 8'h73, 8'h33, 8'h17, 8'h0d, 8'h37, 8'h21, 8'h19
    };

endpackage

FILE: rtl/core/kpbc_rom.sv
// Key table with two synchronous read ports: even entries (start key) and odd entries (key byte).
module kpbc_rom (
    input  logic                        aclk,
    input  logic                        rd_en,
    input  logic [kpbc_pkg::KEY_AW-1:0] even_addr,
    input  logic [kpbc_pkg::KEY_AW-1:0] odd_addr,
    output kpbc_pkg::byte_t             even_q,
    output kpbc_pkg::byte_t             odd_q
);

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            even_q <= kpbc_pkg::KEY_ROM[{even_addr, 1'b0}];
            odd_q  <= kpbc_pkg::KEY_ROM[{odd_addr, 1'b1}];
        end
    end

endmodule

FILE: rtl/core/kpbc_back.sv
// Back stage: applies the key byte, keeps the running sums and holds the output word.
module kpbc_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  load,       // word accepted at the front this cycle
    input  kpbc_pkg::item_t       item_in,
    input  kpbc_pkg::byte_t       key_byte,   // registered table read, aligned with item_reg
    output logic                  ready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata,    // [7:0] out_byte, [15:8] checksum_value,
                                              // [16] check_ok, [23:17] zero
    output logic                  m_tlast     // packet_end
);

    logic            b_valid_reg;
    kpbc_pkg::item_t item_reg;
    logic            advance;

    kpbc_pkg::byte_t plain_sum_reg, plain_sum_next;
    kpbc_pkg::byte_t cipher_sum_reg, cipher_sum_next;
    kpbc_pkg::byte_t exp_sum_reg, exp_sum_next;

    kpbc_pkg::byte_t plain_base, cipher_base, exp_base;
    kpbc_pkg::byte_t delta, body_res, csum;
    logic            add_sel, sum_ok;

    logic            out_valid_reg;
    kpbc_pkg::byte_t out_byte_reg, out_csum_reg;
    logic            out_ok_reg, out_last_reg;

    assign advance = b_valid_reg && (!out_valid_reg || m_tready);
    assign ready   = !b_valid_reg || advance;

    always_comb begin
        case (item_reg.phase)
            kpbc_pkg::PH_SHL1: begin
                delta   = {key_byte[6:0], 1'b0};
                add_sel = (item_reg.mode == kpbc_pkg::MODE_ENC);
            end
            kpbc_pkg::PH_SHR3: begin
                delta   = {3'b000, key_byte[7:3]};
                add_sel = (item_reg.mode == kpbc_pkg::MODE_DEC);
            end
            kpbc_pkg::PH_SHL2: begin
                delta   = {key_byte[5:0], 2'b00};
                add_sel = (item_reg.mode == kpbc_pkg::MODE_ENC);
            end
            kpbc_pkg::PH_SHR5: begin
                delta   = {5'b00000, key_byte[7:5]};
                add_sel = (item_reg.mode == kpbc_pkg::MODE_DEC);
            end
            default: begin
                delta   = '0;
                add_sel = 1'b0;
            end
        endcase
        body_res = add_sel ? item_reg.data + delta : item_reg.data - delta;

        // a first word drops whatever packet was in progress
        plain_base  = item_reg.first ? '0 : plain_sum_reg;
        cipher_base = item_reg.first ? '0 : cipher_sum_reg;
        exp_base    = item_reg.first ? '0 : exp_sum_reg;

        plain_sum_next  = plain_base;
        cipher_sum_next = cipher_base;
        if (item_reg.body) begin
            if (item_reg.mode == kpbc_pkg::MODE_ENC) begin
                plain_sum_next  = plain_base + item_reg.data;
                cipher_sum_next = cipher_base + body_res;
            end else begin
                plain_sum_next  = plain_base + body_res;
                cipher_sum_next = cipher_base + item_reg.data;
            end
        end
        exp_sum_next = item_reg.set_exp ? item_reg.data : exp_base;

        csum   = cipher_sum_next - plain_sum_next;
        sum_ok = (item_reg.mode == kpbc_pkg::MODE_ENC) || (csum == exp_sum_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (load) begin
            b_valid_reg <= 1'b1;
        end else if (advance) begin
            b_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg <= item_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plain_sum_reg  <= '0;
            cipher_sum_reg <= '0;
            exp_sum_reg    <= '0;
        end else if (advance) begin
            if (item_reg.last) begin
                plain_sum_reg  <= '0;
                cipher_sum_reg <= '0;
                exp_sum_reg    <= '0;
            end else begin
                plain_sum_reg  <= plain_sum_next;
                cipher_sum_reg <= cipher_sum_next;
                exp_sum_reg    <= exp_sum_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_byte_reg <= item_reg.body ? body_res : item_reg.data;
            out_csum_reg <= item_reg.last ? csum : '0;
            out_ok_reg   <= item_reg.last && sum_ok;
            out_last_reg <= item_reg.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_ok_reg, out_csum_reg, out_byte_reg};
    assign m_tlast  = out_last_reg;

    a_hold_when_blocked : assert property (@(posedge aclk) disable iff (!aresetn)
        b_valid_reg && !advance |=> b_valid_reg && $stable(item_reg))
        else $error("back stage lost a word while blocked");

    a_sums_clear_at_end : assert property (@(posedge aclk) disable iff (!aresetn)
        advance && item_reg.last |=> plain_sum_reg == '0 && cipher_sum_reg == '0
                                     && exp_sum_reg == '0)
        else $error("packet sums not cleared after last word");

    a_status_only_at_end : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tdata[16:8] == '0)
        else $error("checksum status on a word that is not the last");

endmodule

FILE: rtl/core/keyed_packet_body_cipher.sv
// Top level: front stage (position, mode, key position) plus the key table and back stage.
//
// Byte stream cipher for packets. One byte enters per s_ word: s_tdata carries the data
// byte, the first-byte flag and the encrypt key index, s_tuser selects encrypt (1) or
// decrypt (0) and is sampled with the first byte, s_tlast marks the last byte.
// One m_ word leaves for every s_ word, in order: the transformed byte (header bytes
// 0..3 unchanged), and on the m_tlast word the packet checksum and its match flag.
// Throughput is one byte per cycle while m_tready stays high; back-to-back packets need no gap.
// From acceptance to m_tvalid a word goes through the synchronous key table read and then
// through the add, sum update and output register.
// The key position loaded from the table in a header byte is written in the cycle after that
// byte; the first body byte comes at least two bytes later, so no stall is needed.
// When m_tready is low the output word holds; the back stage keeps one more word and
// s_tready drops once both are full, so no word is lost.
// Reset (aresetn low, synchronous) empties the pipe and clears position, sums,
// mode and key position; the table needs no initialization.
module keyed_packet_body_cipher (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] data_byte, [8] first_byte, [16:9] key_index,
                                   // [23:17] unused
    input  logic        s_tuser,   // func
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] out_byte, [15:8] checksum_value, [16] check_ok,
                                   // [23:17] zero
    output logic        m_tlast    // packet_end
);

    logic                   accept;
    kpbc_pkg::byte_t        in_data, in_key_index;
    logic                   in_first;

    logic [2:0]             pos_reg, pos_next;
    kpbc_pkg::phase_t       phase_reg, phase_next;
    kpbc_pkg::mode_t        mode_reg, mode_next;
    kpbc_pkg::byte_t        key_pos_reg;
    logic                   key_load_reg;

    logic [2:0]             eff_pos;
    kpbc_pkg::phase_t       eff_phase;
    logic                   is_body, load_enc, load_dec;
    logic [kpbc_pkg::KEY_AW-1:0] even_addr;
    kpbc_pkg::byte_t        even_q, odd_q;
    kpbc_pkg::item_t        item;

    assign in_data      = s_tdata[7:0];
    assign in_first     = s_tdata[8];
    assign in_key_index = s_tdata[16:9];
    assign accept       = s_tvalid && s_tready;

    always_comb begin
        eff_pos   = in_first ? 3'd0 : pos_reg;
        eff_phase = in_first ? kpbc_pkg::PH_SHL1 : phase_reg;
        mode_next = in_first ? kpbc_pkg::mode_t'(s_tuser) : mode_reg;
        is_body   = (eff_pos >= kpbc_pkg::HDR_LEN);

        load_enc  = in_first && (mode_next == kpbc_pkg::MODE_ENC);
        load_dec  = (mode_next == kpbc_pkg::MODE_DEC) && (eff_pos == kpbc_pkg::POS_KEY);
        even_addr = load_enc ? in_key_index : in_data;

        if (s_tlast) begin
            pos_next   = 3'd0;
            phase_next = kpbc_pkg::PH_SHL1;
        end else begin
            pos_next   = is_body ? eff_pos : eff_pos + 3'd1;
            phase_next = kpbc_pkg::phase_t'(eff_phase + 2'd1);
        end

        item.first   = in_first;
        item.body    = is_body;
        item.set_exp = (mode_next == kpbc_pkg::MODE_DEC) && (eff_pos == kpbc_pkg::POS_CSUM);
        item.last    = s_tlast;
        item.mode    = mode_next;
        item.phase   = eff_phase;
        item.data    = in_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= 3'd0;
            phase_reg <= kpbc_pkg::PH_SHL1;
            mode_reg  <= kpbc_pkg::MODE_DEC;
        end else if (accept) begin
            pos_reg   <= pos_next;
            phase_reg <= phase_next;
            mode_reg  <= mode_next;
        end
    end

    // table load lands in the cycle after its header byte; body increments happen at accept
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_load_reg <= 1'b0;
            key_pos_reg  <= '0;
        end else begin
            key_load_reg <= accept && (load_enc || load_dec);
            if (key_load_reg) begin
                key_pos_reg <= even_q;
            end else if (accept && is_body) begin
                key_pos_reg <= key_pos_reg + 8'd1;
            end
        end
    end

    kpbc_rom u_rom (
        .aclk      (aclk),
        .rd_en     (accept),
        .even_addr (even_addr),
        .odd_addr  (key_pos_reg),
        .even_q    (even_q),
        .odd_q     (odd_q)
    );

    kpbc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (accept),
        .item_in  (item),
        .key_byte (odd_q),
        .ready    (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    a_no_key_race : assert property (@(posedge aclk) disable iff (!aresetn)
        key_load_reg |-> !(accept && is_body))
        else $error("body byte read key position while a table load was pending");

    a_pos_capped : assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !s_tlast && is_body |=> pos_reg == kpbc_pkg::HDR_LEN)
        else $error("byte position left the body range");

endmodule
